[sv/rk4o_pkg.sv]
// ----------------------------------------------------------------------------
// rk4o_pkg: shared types, constants and functions
// Fixed-point helpers, micro-op encoding and the step program for the
// complex RK4 oscillator step block.
// ----------------------------------------------------------------------------
package rk4o_pkg;

  localparam int DataW = 32;
  localparam int FracW = 24;
  localparam int MagW  = DataW - 1;
  localparam int RfDepth = 16;
  localparam int RfAw = $clog2(RfDepth);
  localparam int PcW = 7;

  localparam logic signed [DataW-1:0] VMAX = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] VMIN = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [MagW-1:0] MAG_MAX = {MagW{1'b1}};
  localparam logic signed [DataW-1:0] ONE = DataW'(64'd1 << FracW);
  localparam logic [MagW-1:0] STEP_RESET = MagW'(167772);
  // reciprocal of three, exact floor for 32-bit dividends after >> 33
  localparam logic signed [DataW:0] RECIP3 = 33'h0AAAAAAAB;

  // configuration register indexes
  localparam logic [1:0] CFG_DRIVE_RE = 2'd0;
  localparam logic [1:0] CFG_DRIVE_IM = 2'd1;
  localparam logic [1:0] CFG_DETUNING = 2'd2;
  localparam logic [1:0] CFG_STEP     = 2'd3;

  typedef logic [4:0] src_t;

  // register file slots
  localparam src_t R_XRE = 5'd0;
  localparam src_t R_XIM = 5'd1;
  localparam src_t R_T0  = 5'd2;
  localparam src_t R_T1  = 5'd3;
  localparam src_t R_W   = 5'd4;
  localparam src_t R_KRE = 5'd5;
  localparam src_t R_KIM = 5'd6;
  localparam src_t R_SRE = 5'd7;
  localparam src_t R_SIM = 5'd8;
  // flop sources and destinations
  localparam src_t S_DRE = 5'd16;
  localparam src_t S_DIM = 5'd17;
  localparam src_t S_DET = 5'd18;
  localparam src_t S_H   = 5'd19;
  localparam src_t S_HH  = 5'd20;
  localparam src_t S_ONE = 5'd21;
  localparam src_t S_PRE = 5'd22;
  localparam src_t S_PIM = 5'd23;
  localparam src_t S_NRE = 5'd24;
  localparam src_t S_NIM = 5'd25;

  typedef enum logic [3:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_MWR,
    OP_RCP, OP_DWR, OP_ACC0, OP_ACC1, OP_SQRT, OP_END
  } op_t;

  typedef struct packed {
    op_t  op;
    src_t dst;
    src_t a;
    src_t b;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic exec;
    logic load_in;
    logic sqrt_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic out_free;
  } status_t;

  // saturating add and subtract
  function automatic logic signed [DataW-1:0] sadd(logic signed [DataW-1:0] a,
                                                   logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) return s[DataW] ? VMIN : VMAX;
    return s[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] ssub(logic signed [DataW-1:0] a,
                                                   logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) return s[DataW] ? VMIN : VMAX;
    return s[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sneg(logic signed [DataW-1:0] a);
    if (a == VMIN) return VMAX;
    return -a;
  endfunction

  // round product to nearest, ties away from zero, then saturate
  function automatic logic signed [DataW-1:0] mul_round(logic signed [2*DataW-1:0] p);
    logic neg;
    logic [2*DataW-1:0] m;
    logic [2*DataW-1:0] r;
    neg = p[2*DataW-1];
    m = neg ? (2*DataW)'(-p) : (2*DataW)'(p);
    r = (m + (64'd1 << (FracW - 1))) >> FracW;
    if (neg) begin
      if (r > {{DataW{1'b0}}, 1'b1, {(DataW-1){1'b0}}}) return VMIN;
      return DataW'(-r[DataW-1:0]);
    end
    if (r > (2*DataW)'(VMAX)) return VMAX;
    return r[DataW-1:0];
  endfunction

  function automatic uop_t mk(op_t op, src_t dst, src_t a, src_t b);
    uop_t u;
    u.op = op;
    u.dst = dst;
    u.a = a;
    u.b = b;
    return u;
  endfunction

  // derivative of the point in XRE/XIM into KRE/KIM
  function automatic uop_t deriv_uop(logic [4:0] i);
    uop_t u;
    u = mk(OP_END, R_T0, R_T0, R_T0);
    case (i)
      5'd0:  u = mk(OP_MUL, R_T0,  R_XRE, R_XRE);
      5'd1:  u = mk(OP_MWR, R_T0,  R_T0,  R_T0);
      5'd2:  u = mk(OP_MUL, R_T1,  R_XIM, R_XIM);
      5'd3:  u = mk(OP_MWR, R_T1,  R_T1,  R_T1);
      5'd4:  u = mk(OP_ADD, R_T0,  R_T0,  R_T1);
      5'd5:  u = mk(OP_ADD, R_W,   S_DET, R_T0);
      5'd6:  u = mk(OP_SUB, R_W,   R_W,   S_ONE);
      5'd7:  u = mk(OP_MUL, R_T0,  R_W,   R_XRE);
      5'd8:  u = mk(OP_MWR, R_T0,  R_T0,  R_T0);
      5'd9:  u = mk(OP_MUL, R_T1,  R_W,   R_XIM);
      5'd10: u = mk(OP_MWR, R_T1,  R_T1,  R_T1);
      5'd11: u = mk(OP_SUB, R_T0,  S_DRE, R_T0);
      5'd12: u = mk(OP_SUB, R_T1,  S_DIM, R_T1);
      5'd13: u = mk(OP_NEG, R_KRE, R_T1,  R_T1);
      5'd14: u = mk(OP_MOV, R_KIM, R_T0,  R_T0);
      default: u = mk(OP_END, R_T0, R_T0, R_T0);
    endcase
    return u;
  endfunction

  // x = p + s * k
  function automatic uop_t axpy_uop(logic [4:0] i, src_t s);
    uop_t u;
    u = mk(OP_END, R_T0, R_T0, R_T0);
    case (i)
      5'd0: u = mk(OP_MUL, R_T0,  s,     R_KRE);
      5'd1: u = mk(OP_MWR, R_T0,  R_T0,  R_T0);
      5'd2: u = mk(OP_ADD, R_XRE, S_PRE, R_T0);
      5'd3: u = mk(OP_MUL, R_T1,  s,     R_KIM);
      5'd4: u = mk(OP_MWR, R_T1,  R_T1,  R_T1);
      5'd5: u = mk(OP_ADD, R_XIM, S_PIM, R_T1);
      default: u = mk(OP_END, R_T0, R_T0, R_T0);
    endcase
    return u;
  endfunction

  // sum += 2 * k
  function automatic uop_t acc2_uop(logic [4:0] i);
    uop_t u;
    u = mk(OP_END, R_T0, R_T0, R_T0);
    case (i)
      5'd0, 5'd1: u = mk(OP_ADD, R_SRE, R_SRE, R_KRE);
      5'd2, 5'd3: u = mk(OP_ADD, R_SIM, R_SIM, R_KIM);
      default: u = mk(OP_END, R_T0, R_T0, R_T0);
    endcase
    return u;
  endfunction

  // last sum terms, final update, magnitude
  function automatic uop_t tail_uop(logic [4:0] i);
    uop_t u;
    u = mk(OP_END, R_T0, R_T0, R_T0);
    case (i)
      5'd0:  u = mk(OP_ADD,  R_SRE, R_SRE, R_KRE);
      5'd1:  u = mk(OP_ADD,  R_SIM, R_SIM, R_KIM);
      5'd2:  u = mk(OP_MUL,  R_T0,  S_H,   R_SRE);
      5'd3:  u = mk(OP_MWR,  R_T0,  R_T0,  R_T0);
      5'd4:  u = mk(OP_RCP,  R_T0,  R_T0,  R_T0);
      5'd5:  u = mk(OP_DWR,  R_T0,  R_T0,  R_T0);
      5'd6:  u = mk(OP_ADD,  S_NRE, S_PRE, R_T0);
      5'd7:  u = mk(OP_MUL,  R_T1,  S_H,   R_SIM);
      5'd8:  u = mk(OP_MWR,  R_T1,  R_T1,  R_T1);
      5'd9:  u = mk(OP_RCP,  R_T1,  R_T1,  R_T1);
      5'd10: u = mk(OP_DWR,  R_T1,  R_T1,  R_T1);
      5'd11: u = mk(OP_ADD,  S_NIM, S_PIM, R_T1);
      5'd12: u = mk(OP_MUL,  R_T0,  S_NRE, S_NRE);
      5'd13: u = mk(OP_ACC0, R_T0,  R_T0,  R_T0);
      5'd14: u = mk(OP_MUL,  R_T0,  S_NIM, S_NIM);
      5'd15: u = mk(OP_ACC1, R_T0,  R_T0,  R_T0);
      5'd16: u = mk(OP_SQRT, R_T0,  R_T0,  R_T0);
      default: u = mk(OP_END, R_T0, R_T0, R_T0);
    endcase
    return u;
  endfunction

  // step program
  function automatic uop_t prog(logic [PcW-1:0] pc);
    uop_t u;
    if (pc < 7'd1)       u = mk(OP_MOV, R_XRE, S_PRE, S_PRE);
    else if (pc < 7'd2)  u = mk(OP_MOV, R_XIM, S_PIM, S_PIM);
    else if (pc < 7'd17) u = deriv_uop(5'(pc - 7'd2));
    else if (pc < 7'd18) u = mk(OP_MOV, R_SRE, R_KRE, R_KRE);
    else if (pc < 7'd19) u = mk(OP_MOV, R_SIM, R_KIM, R_KIM);
    else if (pc < 7'd25) u = axpy_uop(5'(pc - 7'd19), S_HH);
    else if (pc < 7'd40) u = deriv_uop(5'(pc - 7'd25));
    else if (pc < 7'd44) u = acc2_uop(5'(pc - 7'd40));
    else if (pc < 7'd50) u = axpy_uop(5'(pc - 7'd44), S_HH);
    else if (pc < 7'd65) u = deriv_uop(5'(pc - 7'd50));
    else if (pc < 7'd69) u = acc2_uop(5'(pc - 7'd65));
    else if (pc < 7'd75) u = axpy_uop(5'(pc - 7'd69), S_H);
    else if (pc < 7'd90) u = deriv_uop(5'(pc - 7'd75));
    else if (pc < 7'd122) u = tail_uop(5'(pc - 7'd90));
    else u = mk(OP_END, R_T0, R_T0, R_T0);
    return u;
  endfunction

endpackage

[sv/rk4o_ram.sv]
// ----------------------------------------------------------------------------
// rk4o_ram: generic register file memory
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module rk4o_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[sv/rk4o_sqrt.sv]
// ----------------------------------------------------------------------------
// rk4o_sqrt: iterative integer square root
// Two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module rk4o_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2*rk4o_pkg::DataW-1:0]      rad,
  output logic                              done,
  output logic [rk4o_pkg::DataW-1:0]        root
);

  logic [2*rk4o_pkg::DataW-1:0] rad_r;
  logic [rk4o_pkg::DataW+2:0]   rem;
  logic [4:0]                   cnt;
  logic                         busy;
  logic [rk4o_pkg::DataW+2:0]   rem_s;
  logic [rk4o_pkg::DataW+2:0]   trial;

  // shifted remainder and trial value
  always_comb begin
    rem_s = {rem[rk4o_pkg::DataW:0], rad_r[2*rk4o_pkg::DataW-1 -: 2]};
    trial = {1'b0, root, 2'b01};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(rk4o_pkg::DataW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      rad_r <= {rad_r[2*rk4o_pkg::DataW-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[rk4o_pkg::DataW-2:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[rk4o_pkg::DataW-2:0], 1'b0};
      end
    end
  end

endmodule

[sv/rk4o_dp.sv]
// ----------------------------------------------------------------------------
// rk4o_dp: datapath
// Register file, shared multiplier, saturating ALU, square root, config
// registers, running extremes and the output register.
// ----------------------------------------------------------------------------
module rk4o_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  rk4o_pkg::cmd_t        cmd,
  output rk4o_pkg::status_t     status,
  input  logic [63:0]           in_data,
  input  logic                  in_clear,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [31:0]           cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [287:0]          out_data
);

  localparam int DW = rk4o_pkg::DataW;
  localparam int MW = rk4o_pkg::MagW;

  // configuration
  logic signed [DW-1:0] drive_re, drive_im, detuning;
  logic [MW-1:0]        step_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_re  <= '0;
      drive_im  <= '0;
      detuning  <= '0;
      step_size <= rk4o_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rk4o_pkg::CFG_DRIVE_RE: drive_re  <= cfg_data;
        rk4o_pkg::CFG_DRIVE_IM: drive_im  <= cfg_data;
        rk4o_pkg::CFG_DETUNING: detuning  <= cfg_data;
        rk4o_pkg::CFG_STEP:     step_size <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic signed [DW-1:0] p_re, p_im, n_re, n_im;
  logic                 clr;

  // register file
  logic                 rf_we;
  logic [DW-1:0]        rd_a, rd_b;
  logic signed [DW-1:0] wb;

  rk4o_ram #(.WIDTH(DW), .DEPTH(rk4o_pkg::RfDepth)) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (cmd.uop.dst[rk4o_pkg::RfAw-1:0]),
    .wdata   (wb),
    .raddr_a (cmd.uop.a[rk4o_pkg::RfAw-1:0]),
    .rdata_a (rd_a),
    .raddr_b (cmd.uop.b[rk4o_pkg::RfAw-1:0]),
    .rdata_b (rd_b)
  );

  // operand select
  function automatic logic signed [DW-1:0] pick(rk4o_pkg::src_t s, logic [DW-1:0] rd,
      logic signed [DW-1:0] dre, logic signed [DW-1:0] dim, logic signed [DW-1:0] det,
      logic [MW-1:0] h, logic signed [DW-1:0] pre, logic signed [DW-1:0] pim,
      logic signed [DW-1:0] nre, logic signed [DW-1:0] nim);
    logic signed [DW-1:0] v;
    v = rd;
    if (s[4]) begin
      case (s)
        rk4o_pkg::S_DRE: v = dre;
        rk4o_pkg::S_DIM: v = dim;
        rk4o_pkg::S_DET: v = det;
        rk4o_pkg::S_H:   v = {1'b0, h};
        rk4o_pkg::S_HH:  v = {2'b00, h[MW-1:1]};
        rk4o_pkg::S_ONE: v = rk4o_pkg::ONE;
        rk4o_pkg::S_PRE: v = pre;
        rk4o_pkg::S_PIM: v = pim;
        rk4o_pkg::S_NRE: v = nre;
        rk4o_pkg::S_NIM: v = nim;
        default:         v = rd;
      endcase
    end
    return v;
  endfunction

  logic signed [DW-1:0] a_val, b_val;
  logic [DW-1:0]        a_abs;
  logic [DW:0]          a_bias;
  logic signed [DW:0]   ma, mb;
  logic signed [2*DW-1:0] prod;
  logic [2*DW-1:0]      acc;
  logic                 div_neg;
  logic [DW-2:0]        quo;
  logic                 wr_en;

  always_comb begin
    a_val  = pick(cmd.uop.a, rd_a, drive_re, drive_im, detuning, step_size,
                  p_re, p_im, n_re, n_im);
    b_val  = pick(cmd.uop.b, rd_b, drive_re, drive_im, detuning, step_size,
                  p_re, p_im, n_re, n_im);
    a_abs  = a_val[DW-1] ? DW'(-a_val) : DW'(a_val);
    a_bias = {1'b0, a_abs} + (DW+1)'(3);
    quo    = prod[2*DW-1 -: (DW-1)];
    // multiplier operands: signed product or reciprocal divide
    if (cmd.uop.op == rk4o_pkg::OP_RCP) begin
      ma = {1'b0, a_bias[DW:1]};
      mb = rk4o_pkg::RECIP3;
    end else begin
      ma = {a_val[DW-1], a_val};
      mb = {b_val[DW-1], b_val};
    end
  end

  // alu result and writeback enable
  always_comb begin
    wb = a_val;
    wr_en = 1'b0;
    case (cmd.uop.op)
      rk4o_pkg::OP_MOV: begin wb = a_val; wr_en = 1'b1; end
      rk4o_pkg::OP_ADD: begin wb = rk4o_pkg::sadd(a_val, b_val); wr_en = 1'b1; end
      rk4o_pkg::OP_SUB: begin wb = rk4o_pkg::ssub(a_val, b_val); wr_en = 1'b1; end
      rk4o_pkg::OP_NEG: begin wb = rk4o_pkg::sneg(a_val); wr_en = 1'b1; end
      rk4o_pkg::OP_MWR: begin wb = rk4o_pkg::mul_round(prod); wr_en = 1'b1; end
      rk4o_pkg::OP_DWR: begin
        wb = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        wr_en = 1'b1;
      end
      default: begin wb = a_val; wr_en = 1'b0; end
    endcase
    rf_we = cmd.exec && wr_en && !cmd.uop.dst[4];
  end

  // input item load, multiplier, accumulator, flop destinations
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      p_re <= in_data[DW-1:0];
      p_im <= in_data[2*DW-1:DW];
      clr  <= in_clear;
    end
    if (cmd.exec) begin
      case (cmd.uop.op)
        rk4o_pkg::OP_MUL: prod <= (2*DW)'(ma * mb);
        rk4o_pkg::OP_RCP: begin
          prod    <= (2*DW)'(ma * mb);
          div_neg <= a_val[DW-1];
        end
        rk4o_pkg::OP_ACC0: acc <= prod;
        rk4o_pkg::OP_ACC1: acc <= acc + prod;
        default: ;
      endcase
      if (wr_en && cmd.uop.dst == rk4o_pkg::S_NRE) n_re <= wb;
      if (wr_en && cmd.uop.dst == rk4o_pkg::S_NIM) n_im <= wb;
    end
  end

  // square root of re^2 + im^2
  logic          sq_done;
  logic [DW-1:0] sq_root;

  rk4o_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .rad   (acc),
    .done  (sq_done),
    .root  (sq_root)
  );

  // running extremes and output register
  logic signed [DW-1:0] min_re, max_re, min_im, max_im;
  logic [MW-1:0]        min_mag, max_mag;
  logic signed [DW-1:0] b_min_re, b_max_re, b_min_im, b_max_im;
  logic [MW-1:0]        b_min_mag, b_max_mag, mag;
  logic signed [DW-1:0] min_re_next, max_re_next, min_im_next, max_im_next;
  logic [MW-1:0]        min_mag_next, max_mag_next;

  always_comb begin
    mag       = sq_root[DW-1] ? rk4o_pkg::MAG_MAX : sq_root[MW-1:0];
    b_min_re  = clr ? rk4o_pkg::VMAX : min_re;
    b_max_re  = clr ? rk4o_pkg::VMIN : max_re;
    b_min_im  = clr ? rk4o_pkg::VMAX : min_im;
    b_max_im  = clr ? rk4o_pkg::VMIN : max_im;
    b_min_mag = clr ? rk4o_pkg::MAG_MAX : min_mag;
    b_max_mag = clr ? '0 : max_mag;
    min_re_next  = (n_re < b_min_re) ? n_re : b_min_re;
    max_re_next  = (n_re > b_max_re) ? n_re : b_max_re;
    min_im_next  = (n_im < b_min_im) ? n_im : b_min_im;
    max_im_next  = (n_im > b_max_im) ? n_im : b_max_im;
    min_mag_next = (mag < b_min_mag) ? mag : b_min_mag;
    max_mag_next = (mag > b_max_mag) ? mag : b_max_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_re    <= rk4o_pkg::VMAX;
      max_re    <= rk4o_pkg::VMIN;
      min_im    <= rk4o_pkg::VMAX;
      max_im    <= rk4o_pkg::VMIN;
      min_mag   <= rk4o_pkg::MAG_MAX;
      max_mag   <= '0;
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      min_re    <= min_re_next;
      max_re    <= max_re_next;
      min_im    <= min_im_next;
      max_im    <= max_im_next;
      min_mag   <= min_mag_next;
      max_mag   <= max_mag_next;
      out_valid <= 1'b1;
      out_data  <= {3'b000, max_mag_next, min_mag_next, max_im_next, min_im_next,
                    max_re_next, min_re_next, mag, n_im, n_re};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.sqrt_done = sq_done;
  assign status.out_free  = !out_valid || out_ready;

endmodule

[sv/rk4o_ctrl.sv]
// ----------------------------------------------------------------------------
// rk4o_ctrl: controller
// Steps through the micro-op program, each op in a read state (register file
// read), then an execute state, and waits on the square root and the output.
// ----------------------------------------------------------------------------
module rk4o_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rk4o_pkg::status_t   status,
  output rk4o_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_SQRT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                        state, state_next;
  logic [rk4o_pkg::PcW-1:0]      pc, pc_next;
  rk4o_pkg::uop_t                uop;

  assign uop = rk4o_pkg::prog(pc);
  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    pc_next        = pc;
    cmd.uop        = uop;
    cmd.exec       = 1'b0;
    cmd.load_in    = 1'b0;
    cmd.sqrt_start = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_next     = '0;
          state_next  = ST_READ;
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (uop.op == rk4o_pkg::OP_SQRT) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ST_SQRT;
        end else if (uop.op == rk4o_pkg::OP_END) begin
          state_next = ST_DONE;
        end else begin
          cmd.exec   = 1'b1;
          pc_next    = pc + 7'd1;
          state_next = ST_READ;
        end
      end
      ST_SQRT: begin
        if (status.sqrt_done) begin
          pc_next    = pc + 7'd1;
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

[sv/complex_rk4_oscillator_step_top.sv]
// ----------------------------------------------------------------------------
// complex_rk4_oscillator_step_top: one RK4 step of a driven complex oscillator
// Each item runs 106 micro-ops, each in a register file read state and then
// an execute state, on the shared multiplier and register file, plus the
// square root. One item is in flight at a time; the next item is taken while a
// finished result still waits in the output register.
// Synchronous reset clears control, extremes and loads register defaults.
// ----------------------------------------------------------------------------
module complex_rk4_oscillator_step_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // p_re, p_im
  input  logic         s_tuser,   // clear_extremes
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // next_re, next_im, next_mag, low_re, high_re,
                                  // low_im, high_im, low_mag, high_mag, zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  rk4o_pkg::cmd_t    cmd;
  rk4o_pkg::status_t status;

  // sequencer
  rk4o_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and result storage
  rk4o_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_clear  (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

[tb/complex_rk4_oscillator_step_top_tb.sv]
// ----------------------------------------------------------------------------
// complex_rk4_oscillator_step_top_tb: self-checking bench for the RK4 step
// Sends complex samples over the input stream under several register
// settings, predicts each stepped sample, its magnitude and the running
// extremes, and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module complex_rk4_oscillator_step_top_tb;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int HOLD_LEN = 3000;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [63:0] data;
    logic        clr;
  } sample_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_data;

  complex_rk4_oscillator_step_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // predictor state
  longint drv_re, drv_im, det, hstep;
  longint lo_re, hi_re, lo_im, hi_im, lo_mag, hi_mag;

  sample_t      pending[$];
  logic [287:0] expected_out[$];
  int  items_in;
  int  errors;
  int  stall_cycles;
  int  hold_cnt;
  bit  hold_done;

  function automatic longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = (ma * mb + 64'd8388608) >> rk4o_pkg::FracW;
    if (neg) return (r > 64'd2147483648) ? SMIN : -longint'(r);
    return (r > 64'd2147483647) ? SMAX : longint'(r);
  endfunction

  function automatic void deriv(input longint pr, input longint pi,
                                output longint kr, output longint ki);
    longint w;
    w = sat(sat(det + sat(fmul(pr, pr) + fmul(pi, pi))) - (64'sd1 << rk4o_pkg::FracW));
    kr = sat(-sat(drv_im - fmul(w, pi)));
    ki = sat(drv_re - fmul(w, pr));
  endfunction

  function automatic longint div_six(longint x);
    longint unsigned q;
    q = ((x < 0 ? -x : x) + 3) / 6;
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint isqrt_mag(longint re, longint im);
    longint unsigned n, res, cand;
    n = longint'(re * re) + longint'(im * im);
    res = 0;
    for (int b = rk4o_pkg::DataW - 1; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= n) res = cand;
    end
    return res > 64'd2147483647 ? SMAX : longint'(res);
  endfunction

  // one step of the oscillator plus extreme tracking
  function automatic logic [287:0] osc_step(sample_t s);
    longint pr, pi, hh, k1r, k1i, k2r, k2i, k3r, k3i, k4r, k4i, sr, si, nr, ni, mg;
    logic [287:0] o;
    pr = longint'(signed'(s.data[31:0]));
    pi = longint'(signed'(s.data[63:32]));
    hh = hstep >> 1;
    if (s.clr) begin
      lo_re = SMAX; hi_re = SMIN; lo_im = SMAX; hi_im = SMIN; lo_mag = SMAX; hi_mag = 0;
    end
    deriv(pr, pi, k1r, k1i);
    deriv(sat(pr + fmul(hh, k1r)), sat(pi + fmul(hh, k1i)), k2r, k2i);
    deriv(sat(pr + fmul(hh, k2r)), sat(pi + fmul(hh, k2i)), k3r, k3i);
    deriv(sat(pr + fmul(hstep, k3r)), sat(pi + fmul(hstep, k3i)), k4r, k4i);
    sr = sat(sat(sat(sat(sat(k1r + k2r) + k2r) + k3r) + k3r) + k4r);
    si = sat(sat(sat(sat(sat(k1i + k2i) + k2i) + k3i) + k3i) + k4i);
    nr = sat(pr + div_six(fmul(hstep, sr)));
    ni = sat(pi + div_six(fmul(hstep, si)));
    mg = isqrt_mag(nr, ni);
    if (nr < lo_re) lo_re = nr;
    if (nr > hi_re) hi_re = nr;
    if (ni < lo_im) lo_im = ni;
    if (ni > hi_im) hi_im = ni;
    if (mg < lo_mag) lo_mag = mg;
    if (mg > hi_mag) hi_mag = mg;
    o = '0;
    o[31:0] = nr[31:0];
    o[63:32] = ni[31:0];
    o[94:64] = mg[30:0];
    o[126:95] = lo_re[31:0];
    o[158:127] = hi_re[31:0];
    o[190:159] = lo_im[31:0];
    o[222:191] = hi_im[31:0];
    o[253:223] = lo_mag[30:0];
    o[284:254] = hi_mag[30:0];
    return o;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input driver, predicts on every accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      items_in <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_out.push_back(osc_step('{s_tdata, s_tuser}));
        items_in <= items_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 &&
            ((items_in > 450 && items_in < 560) || $urandom_range(0, 99) >= 28)) begin
          sample_t s;
          s = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= s.data;
          s_tuser <= s.clr;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output ready with random idling and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_in >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (items_in > 600 && items_in < 700) || $urandom_range(0, 99) >= 28;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output transfer %h", m_tdata);
      end else begin
        logic [287:0] e;
        int lo_bit [9];
        int wid [9];
        bit bad;
        lo_bit = '{0, 32, 64, 95, 127, 159, 191, 223, 254};
        wid = '{32, 32, 31, 32, 32, 32, 32, 31, 31};
        e = expected_out.pop_front();
        bad = 1'b0;
        for (int f = 0; f < 9; f++) begin
          logic [31:0] ev, av;
          ev = 32'((e >> lo_bit[f]) & ((64'd1 << wid[f]) - 1));
          av = 32'((m_tdata >> lo_bit[f]) & ((64'd1 << wid[f]) - 1));
          if (ev !== av) begin
            if (!bad) errors++;
            if (!bad && errors <= 10)
              $display("field %0d mismatch: expected %h got %h", f, ev, av);
            bad = 1'b1;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("complex_rk4_oscillator_step_top_tb: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rk4o_pkg::CFG_DRIVE_RE: drv_re = longint'(signed'(val));
      rk4o_pkg::CFG_DRIVE_IM: drv_im = longint'(signed'(val));
      rk4o_pkg::CFG_DETUNING: det = longint'(signed'(val));
      rk4o_pkg::CFG_STEP:     hstep = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic add_sample(logic [31:0] re, logic [31:0] im, logic clr);
    pending.push_back('{{im, re}, clr});
  endtask

  // samples within plus or minus two on each axis, some full range
  task automatic add_random(int n);
    logic [31:0] re, im;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        re = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        im = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      end else begin
        re = $urandom;
        im = $urandom;
      end
      add_sample(re, im, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || s_tvalid || expected_out.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = rk4o_pkg::CFG_DRIVE_RE;
    cfg_data = '0;
    errors = 0;
    drv_re = 0; drv_im = 0; det = 0; hstep = 167772;
    lo_re = SMAX; hi_re = SMIN; lo_im = SMAX; hi_im = SMIN; lo_mag = SMAX; hi_mag = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, directed extremes
    add_sample(32'h0, 32'h0, 1'b0);
    add_sample(32'h0100_0000, 32'h0, 1'b0);
    add_sample(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    add_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_sample(32'hffff_ffff, 32'h0000_0001, 1'b1);
    add_sample(32'h0, 32'hff00_0000, 1'b0);
    add_random(150);
    drain();

    // mild drive and detuning
    write_reg(rk4o_pkg::CFG_DRIVE_RE, 32'h0080_0000);
    write_reg(rk4o_pkg::CFG_DRIVE_IM, 32'hffc0_0000);
    write_reg(rk4o_pkg::CFG_DETUNING, 32'h0200_0000);
    write_reg(rk4o_pkg::CFG_STEP, 32'd1677722);
    add_sample(32'h0100_0000, 32'h0100_0000, 1'b1);
    add_sample(32'h7fff_ffff, 32'h0, 1'b0);
    add_random(400);
    drain();

    // extreme registers, largest step
    write_reg(rk4o_pkg::CFG_DRIVE_RE, 32'h7fff_ffff);
    write_reg(rk4o_pkg::CFG_DRIVE_IM, 32'h8000_0000);
    write_reg(rk4o_pkg::CFG_DETUNING, 32'h8000_0000);
    write_reg(rk4o_pkg::CFG_STEP, 32'hffff_ffff);
    add_sample(32'h0, 32'h0, 1'b1);
    add_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_random(100);
    drain();

    // zero step, opposite extremes
    write_reg(rk4o_pkg::CFG_DRIVE_RE, 32'h8000_0000);
    write_reg(rk4o_pkg::CFG_DRIVE_IM, 32'h7fff_ffff);
    write_reg(rk4o_pkg::CFG_DETUNING, 32'h7fff_ffff);
    write_reg(rk4o_pkg::CFG_STEP, 32'h0);
    add_sample(32'h1234_5678, 32'h8765_4321, 1'b1);
    add_random(80);
    drain();

    // random settings
    write_reg(rk4o_pkg::CFG_DRIVE_RE, $urandom);
    write_reg(rk4o_pkg::CFG_DRIVE_IM, $urandom);
    write_reg(rk4o_pkg::CFG_DETUNING, $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
    write_reg(rk4o_pkg::CFG_STEP, $urandom_range(0, 32'h0100_0000));
    add_random(170);
    drain();

    if (errors == 0) begin
      $display("complex_rk4_oscillator_step_top_tb: clean");
    end else begin
      $display("complex_rk4_oscillator_step_top_tb: errors");
    end
    $finish;
  end

endmodule
